// File: src/hat_pkg.sv
// Shared types and constants for the holding accumulation tracker.
package hat_pkg;

  localparam int TOTAL_BITS    = 40;
  localparam int FRACTION_BITS = 16;
  localparam int VOLUME_BITS   = 32;
  localparam int PRICE_BITS    = 24;
  localparam int LO_BITS       = (PRICE_BITS > FRACTION_BITS + 1) ? PRICE_BITS
                                                                  : FRACTION_BITS + 1;
  localparam int CNT_BITS      = $clog2(LO_BITS);

  typedef struct packed {
    logic                          series_start;
    logic signed [VOLUME_BITS-1:0] net_volume;
    logic [PRICE_BITS-1:0]         price;
  } hat_in_t;

  typedef struct packed {
    logic signed [TOTAL_BITS-1:0] running_total;
    logic signed [TOTAL_BITS-1:0] lowest_total;
    logic [TOTAL_BITS-1:0]        holding;
    logic [PRICE_BITS-1:0]        average_price;
    logic [TOTAL_BITS-1:0]        peak_holding;
    logic [FRACTION_BITS:0]       holding_fraction;
  } hat_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_LOW,
    ST_HOLD,
    ST_PREP,
    ST_MUL,
    ST_DIVA,
    ST_FLOAD,
    ST_DIVF,
    ST_DONE
  } hat_state_t;

  typedef enum logic [2:0] {
    UOP_IDLE,
    UOP_LOAD_MUL,
    UOP_MUL,
    UOP_DIV,
    UOP_LOAD_FRAC
  } hat_uop_t;

  typedef struct packed {
    logic accept;
    logic use_div;
    logic peak_zero;
    logic out_free;
  } hat_stat_t;

  typedef struct packed {
    hat_state_t state;
    hat_uop_t   uop;
  } hat_ctrl_t;

endpackage

// File: src/holding_accumulation_tracker.sv
// Top level of the holding accumulation tracker.
//
// One daily record enters on the in_ channel (in_valid, in_stall, in_data) and
// produces exactly one result item on the out_ channel (out_valid, out_stall,
// out_data). A record with series_start set clears all running state first.
// Each record is processed alone: the saturating total, lowest total, holding
// and peak are formed in the states SUM, LOW, HOLD and PREP, then one shared
// bit-serial unit forms the weighted cost numerator and divides it for the
// average price, loads the holding and divides it by peak for the fraction,
// and the DONE state loads the result into the output register.
// The multiply and average division are skipped when the holding or the
// previous average is zero, and the fraction division when peak is zero.
// The next record can be accepted in the cycle after the result is loaded at
// the earliest, so the block takes no new record before that.
// in_stall is high from acceptance until the result is loaded into the output
// register. The output register holds the result while out_stall is high; a
// new record may be accepted meanwhile, but its result waits until the old one
// is taken. Reset clears all running state and drops out_valid.
module holding_accumulation_tracker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hat_pkg::hat_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output hat_pkg::hat_out_t out_data
);
  import hat_pkg::*;

  localparam logic [TOTAL_BITS-1:0] SUM_MAX = {1'b0, {(TOTAL_BITS-1){1'b1}}};
  localparam logic [TOTAL_BITS-1:0] SUM_MIN = {1'b1, {(TOTAL_BITS-1){1'b0}}};

  hat_stat_t stat;
  hat_ctrl_t ctrl;

  logic signed [TOTAL_BITS-1:0]  sum_r, low_r;
  logic [TOTAL_BITS-1:0]         hold_r, peak_r, phold_r, inc_r, den_r;
  logic [PRICE_BITS-1:0]         pavg_r, avg_r, price_r;
  logic [VOLUME_BITS-1:0]        vol_r;
  logic                          div_used_r;
  logic                          out_valid_r;
  hat_out_t                      out_data_r;

  logic [TOTAL_BITS:0]           ext;
  logic                          ovf;
  logic [TOTAL_BITS-1:0]         sum_sat;
  logic                          hold_gt;
  logic [TOTAL_BITS-1:0]         unit_den;
  logic [LO_BITS-1:0]            quo;
  logic                          accept;
  logic                          load_out;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (ctrl.state != ST_IDLE);
  assign load_out = (ctrl.state == ST_DONE) && stat.out_free;

  always_comb begin
    stat.accept    = accept;
    stat.use_div   = (hold_r != '0) && (pavg_r != '0);
    stat.peak_zero = (peak_r == '0);
    stat.out_free  = !out_valid_r || !out_stall;
  end

  always_comb begin
    ext = {sum_r[TOTAL_BITS-1], sum_r}
        + {{(TOTAL_BITS+1-VOLUME_BITS){vol_r[VOLUME_BITS-1]}}, vol_r};
    ovf = (ext[TOTAL_BITS] != ext[TOTAL_BITS-1]);
    sum_sat = ovf ? (ext[TOTAL_BITS] ? SUM_MIN : SUM_MAX) : ext[TOTAL_BITS-1:0];
    hold_gt = (hold_r > phold_r);
    unit_den = (ctrl.state == ST_DIVF) ? peak_r : den_r;
  end

  hat_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  hat_unit u_unit (
    .clk      (clk),
    .uop      (ctrl.uop),
    .mul_a    (pavg_r),
    .mul_b    (price_r),
    .op_a     (phold_r),
    .op_b     (inc_r),
    .den      (unit_den),
    .load_val (hold_r),
    .quo      (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      low_r   <= '0;
      peak_r  <= '0;
      pavg_r  <= '0;
      phold_r <= '0;
    end else begin
      priority if (accept && in_data.series_start) begin
        sum_r   <= '0;
        low_r   <= '0;
        peak_r  <= '0;
        pavg_r  <= '0;
        phold_r <= '0;
      end else if (ctrl.state == ST_SUM) begin
        sum_r <= sum_sat;
      end else if (ctrl.state == ST_LOW) begin
        if (sum_r < low_r) low_r <= sum_r;
      end else if (ctrl.state == ST_PREP) begin
        if (hold_r > peak_r) peak_r <= hold_r;
      end else if (load_out) begin
        phold_r <= hold_r;
        pavg_r  <= avg_r;
      end else begin
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vol_r   <= in_data.net_volume;
      price_r <= in_data.price;
    end
    if (ctrl.state == ST_HOLD) begin
      hold_r <= sum_r - low_r;
    end
    if (ctrl.state == ST_PREP) begin
      inc_r      <= hold_gt ? hold_r - phold_r : '0;
      den_r      <= hold_gt ? hold_r : phold_r;
      div_used_r <= stat.use_div;
      if (!stat.use_div) avg_r <= price_r;
    end
    if (ctrl.state == ST_FLOAD && div_used_r) begin
      avg_r <= quo[PRICE_BITS-1:0];
    end
    if (load_out) begin
      out_data_r.running_total    <= sum_r;
      out_data_r.lowest_total     <= low_r;
      out_data_r.holding          <= hold_r;
      out_data_r.average_price    <= avg_r;
      out_data_r.peak_holding     <= peak_r;
      out_data_r.holding_fraction <= stat.peak_zero ? '0 : quo[FRACTION_BITS:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(ctrl.state == ST_DONE))
    else $error("result appeared without a finished record");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ctrl.state == ST_SUM)
    else $error("accepted item did not start the sequence");

  a_low_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.lowest_total[TOTAL_BITS-1] || (out_data.lowest_total == '0))
    else $error("lowest total is positive");

  a_hold_le_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.holding <= out_data.peak_holding)
    else $error("holding exceeds peak holding");

endmodule

// File: src/hat_unit.sv
// Shared shift-add multiplier and restoring divider working one bit per cycle.
module hat_unit (
  input  logic                               clk,
  input  hat_pkg::hat_uop_t                  uop,
  input  logic [hat_pkg::PRICE_BITS-1:0]     mul_a,
  input  logic [hat_pkg::PRICE_BITS-1:0]     mul_b,
  input  logic [hat_pkg::TOTAL_BITS-1:0]     op_a,
  input  logic [hat_pkg::TOTAL_BITS-1:0]     op_b,
  input  logic [hat_pkg::TOTAL_BITS-1:0]     den,
  input  logic [hat_pkg::TOTAL_BITS-1:0]     load_val,
  output logic [hat_pkg::LO_BITS-1:0]        quo
);
  import hat_pkg::*;

  logic [TOTAL_BITS:0]   hi_r, hi_nxt;
  logic [LO_BITS-1:0]    lo_r, lo_nxt;
  logic [PRICE_BITS-1:0] ma_r, ma_nxt;
  logic [PRICE_BITS-1:0] mb_r, mb_nxt;
  logic [TOTAL_BITS+1:0] acc;
  logic [TOTAL_BITS:0]   rem2;
  logic [TOTAL_BITS:0]   diff;
  logic                  ge;

  always_comb begin
    acc  = {1'b0, hi_r} + {2'b00, (ma_r[0] ? op_a : '0)} + {2'b00, (mb_r[0] ? op_b : '0)};
    rem2 = {hi_r[TOTAL_BITS-1:0], lo_r[LO_BITS-1]};
    diff = rem2 - {1'b0, den};
    ge   = (rem2 >= {1'b0, den});
  end

  always_comb begin
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    ma_nxt = ma_r;
    mb_nxt = mb_r;
    unique case (uop)
      UOP_LOAD_MUL: begin
        hi_nxt = '0;
        lo_nxt = '0;
        ma_nxt = mul_a;
        mb_nxt = mul_b;
      end
      UOP_MUL: begin
        hi_nxt = acc[TOTAL_BITS+1:1];
        lo_nxt = {acc[0], lo_r[LO_BITS-1:1]};
        ma_nxt = {1'b0, ma_r[PRICE_BITS-1:1]};
        mb_nxt = {1'b0, mb_r[PRICE_BITS-1:1]};
      end
      UOP_DIV: begin
        hi_nxt = {1'b0, (ge ? diff[TOTAL_BITS-1:0] : rem2[TOTAL_BITS-1:0])};
        lo_nxt = {lo_r[LO_BITS-2:0], ge};
      end
      UOP_LOAD_FRAC: begin
        hi_nxt = {2'b00, load_val[TOTAL_BITS-1:1]};
        lo_nxt = '0;
        lo_nxt[LO_BITS-1] = load_val[0];
      end
      UOP_IDLE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    ma_r <= ma_nxt;
    mb_r <= mb_nxt;
  end

  assign quo = lo_r;

endmodule

// File: src/hat_ctrl.sv
// Sequencer that steps one record through the update, multiply and divide phases.
module hat_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  hat_pkg::hat_stat_t stat,
  output hat_pkg::hat_ctrl_t ctrl
);
  import hat_pkg::*;

  hat_state_t          state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                last;

  always_comb begin
    unique case (state_r)
      ST_MUL, ST_DIVA: last = (cnt_r == CNT_BITS'(PRICE_BITS - 1));
      ST_DIVF:         last = (cnt_r == CNT_BITS'(FRACTION_BITS));
      default:         last = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (stat.accept) state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_LOW;
      ST_LOW:   state_nxt = ST_HOLD;
      ST_HOLD:  state_nxt = ST_PREP;
      ST_PREP:  state_nxt = stat.use_div ? ST_MUL : ST_FLOAD;
      ST_MUL:   if (last) state_nxt = ST_DIVA;
      ST_DIVA:  if (last) state_nxt = ST_FLOAD;
      ST_FLOAD: state_nxt = stat.peak_zero ? ST_DONE : ST_DIVF;
      ST_DIVF:  if (last) state_nxt = ST_DONE;
      ST_DONE:  if (stat.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
    cnt_nxt = (state_nxt != state_r) ? '0 : cnt_r + 1'b1;
  end

  always_comb begin
    ctrl.state = state_r;
    unique case (state_r)
      ST_PREP:  ctrl.uop = stat.use_div ? UOP_LOAD_MUL : UOP_IDLE;
      ST_MUL:   ctrl.uop = UOP_MUL;
      ST_DIVA:  ctrl.uop = UOP_DIV;
      ST_DIVF:  ctrl.uop = UOP_DIV;
      ST_FLOAD: ctrl.uop = stat.peak_zero ? UOP_IDLE : UOP_LOAD_FRAC;
      default:  ctrl.uop = UOP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
